// ----- rtl/sik_pkg.sv -----
// ---------------------------------------------------------------------------
// sik_pkg: shared types and constants of the swerve inverse kinematics
// Fixed point formats, CORDIC angle table, stage payload structs.
// ---------------------------------------------------------------------------
package sik_pkg;

    localparam int FRAC_BITS     = 16;
    localparam int CORDIC_STAGES = 16;
    localparam int NUM_WHEELS    = 3;

    localparam int XW     = 44;              // CORDIC x/y width
    localparam int ZW     = 22;              // CORDIC angle width
    localparam int VW     = 41;              // wheel velocity width
    localparam int MW     = 43;              // magnitude width
    localparam int RW     = 23;              // radius width
    localparam int ANG_W  = 19;
    localparam int RATE_W = 31;
    localparam int STAMP_W = 63;
    localparam int LOW_W  = RATE_W - FRAC_BITS;   // dividend bits still to shift in
    localparam int REM_W  = RW + 1;
    localparam int DIV_STEPS = RATE_W;

    localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;
    localparam longint PI_Q30 = 64'd3373259426;
    localparam int Q30_SH = 30 - FRAC_BITS;

    localparam logic signed [ZW-1:0] PI_FRAC =
        ZW'((PI_Q30 + (64'd1 << (Q30_SH - 1))) >> Q30_SH);

    localparam longint ATAN_Q30 [24] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288,
        262144, 131072, 65536, 32768, 16384, 8192,
        4096, 2048, 1024, 512, 256, 128
    };

    localparam logic [RATE_W-1:0] RATE_MAX = '1;

    typedef enum logic [2:0] {
        CFG_W0_X   = 3'd0,
        CFG_W0_Y   = 3'd1,
        CFG_W1_X   = 3'd2,
        CFG_W1_Y   = 3'd3,
        CFG_W2_X   = 3'd4,
        CFG_W2_Y   = 3'd5,
        CFG_RADIUS = 3'd6
    } t_cfg_reg;

    typedef struct packed {
        logic               vld;
        logic [1:0]         wheel;
        logic               last;
        logic [STAMP_W-1:0] stamp;
        logic               nul;
    } t_tag;

    typedef struct packed {
        t_tag                    tag;
        logic                    sat;
        logic signed [ANG_W-1:0] angle;
    } t_dside;

    function automatic logic signed [ZW-1:0] atan_frac(input int i);
        atan_frac = ZW'((ATAN_Q30[i] + (64'd1 << (Q30_SH - 1))) >> Q30_SH);
    endfunction

endpackage

// ----- rtl/sik_cordic_cell.sv -----
// ---------------------------------------------------------------------------
// sik_cordic_cell: one vectoring CORDIC micro-rotation
// Rotates (x, y) towards the x axis and accumulates the angle.
// ---------------------------------------------------------------------------
module sik_cordic_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic [4:0]                    i_shift,
    input  logic signed [sik_pkg::ZW-1:0] i_atan,
    input  sik_pkg::t_tag                 i_tag,
    input  logic signed [sik_pkg::XW-1:0] i_x,
    input  logic signed [sik_pkg::XW-1:0] i_y,
    input  logic signed [sik_pkg::ZW-1:0] i_z,
    output sik_pkg::t_tag                 o_tag,
    output logic signed [sik_pkg::XW-1:0] o_x,
    output logic signed [sik_pkg::XW-1:0] o_y,
    output logic signed [sik_pkg::ZW-1:0] o_z
);
    sik_pkg::t_tag                 r_tag;
    logic signed [sik_pkg::XW-1:0] r_x, r_y, n_x, n_y, xs, ys;
    logic signed [sik_pkg::ZW-1:0] r_z, n_z;

    always_comb begin
        xs = i_x >>> i_shift;
        ys = i_y >>> i_shift;
        if (i_y > 0) begin
            n_x = i_x + ys;
            n_y = i_y - xs;
            n_z = i_z + i_atan;
        end else begin
            n_x = i_x - ys;
            n_y = i_y + xs;
            n_z = i_z - i_atan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
        end else if (i_en) begin
            r_tag <= i_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_tag = r_tag;
    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_z   = r_z;
endmodule

// ----- rtl/sik_div_cell.sv -----
// ---------------------------------------------------------------------------
// sik_div_cell: one restoring division step
// Shifts in one dividend bit, trial-subtracts the radius, emits a quotient bit.
// ---------------------------------------------------------------------------
module sik_div_cell (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic [sik_pkg::RW-1:0]           i_radius,
    input  sik_pkg::t_dside                  i_side,
    input  logic [sik_pkg::REM_W-1:0]        i_rem,
    input  logic [sik_pkg::LOW_W-1:0]        i_low,
    input  logic [sik_pkg::RATE_W-1:0]       i_quo,
    output sik_pkg::t_dside                  o_side,
    output logic [sik_pkg::REM_W-1:0]        o_rem,
    output logic [sik_pkg::LOW_W-1:0]        o_low,
    output logic [sik_pkg::RATE_W-1:0]       o_quo
);
    sik_pkg::t_dside                  r_side;
    logic [sik_pkg::REM_W-1:0]        r_rem, n_rem, trial;
    logic [sik_pkg::LOW_W-1:0]        r_low;
    logic [sik_pkg::RATE_W-1:0]       r_quo;
    logic                             qbit;

    always_comb begin
        trial = {i_rem[sik_pkg::REM_W-2:0], i_low[sik_pkg::LOW_W-1]};
        qbit  = (trial >= {1'b0, i_radius});
        n_rem = qbit ? (trial - {1'b0, i_radius}) : trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= '0;
        end else if (i_en) begin
            r_side <= i_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_low <= {i_low[sik_pkg::LOW_W-2:0], 1'b0};
            r_quo <= {i_quo[sik_pkg::RATE_W-2:0], qbit};
        end
    end

    assign o_side = r_side;
    assign o_rem  = r_rem;
    assign o_low  = r_low;
    assign o_quo  = r_quo;
endmodule

// ----- rtl/swerve_inverse_kinematics.sv -----
// ---------------------------------------------------------------------------
// swerve_inverse_kinematics: chassis twist to three wheel steer/rate commands
// Per wheel: velocity products, CORDIC vectoring chain, gain, divider chain.
// ---------------------------------------------------------------------------
// Throughput: one wheel result per cycle while the output does not stall; the
// single issue slot of the wheel sequencer feeding the cell chains sets this.
// A new twist is taken when idle or as the previous one's last wheel issues.
// The whole pipeline holds while a result waits on the output.
// Reset: synchronous active low; clears pipeline valids, positions to 0,
// radius to 6554.
module swerve_inverse_kinematics (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [2:0]                         i_cfg_index,
    input  logic [23:0]                        i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic signed [31:0]                 i_vel_x,
    input  logic signed [31:0]                 i_vel_y,
    input  logic signed [31:0]                 i_yaw_rate,
    input  logic [sik_pkg::STAMP_W-1:0]        i_stamp_ns,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [1:0]                         o_wheel_num,
    output logic signed [sik_pkg::ANG_W-1:0]   o_steer_angle,
    output logic [sik_pkg::RATE_W-1:0]         o_wheel_rate,
    output logic [sik_pkg::STAMP_W-1:0]        o_out_stamp_ns,
    output logic                               o_last_wheel
);
    localparam int NC = sik_pkg::CORDIC_STAGES;
    localparam int ND = sik_pkg::DIV_STEPS;

    // configuration
    logic signed [23:0]        r_pos_x [sik_pkg::NUM_WHEELS];
    logic signed [23:0]        r_pos_y [sik_pkg::NUM_WHEELS];
    logic [sik_pkg::RW-1:0]    r_radius;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < sik_pkg::NUM_WHEELS; k++) begin
                r_pos_x[k] <= '0;
                r_pos_y[k] <= '0;
            end
            r_radius <= sik_pkg::RW'(6554);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                sik_pkg::CFG_W0_X:   r_pos_x[0] <= i_cfg_data;
                sik_pkg::CFG_W0_Y:   r_pos_y[0] <= i_cfg_data;
                sik_pkg::CFG_W1_X:   r_pos_x[1] <= i_cfg_data;
                sik_pkg::CFG_W1_Y:   r_pos_y[1] <= i_cfg_data;
                sik_pkg::CFG_W2_X:   r_pos_x[2] <= i_cfg_data;
                sik_pkg::CFG_W2_Y:   r_pos_y[2] <= i_cfg_data;
                sik_pkg::CFG_RADIUS: r_radius   <= i_cfg_data[sik_pkg::RW-1:0];
                default: ;
            endcase
        end
    end

    // global advance: everything moves unless a result is held on the output
    logic r_out_valid;
    logic en;
    assign en = !r_out_valid || i_out_ready;

    // wheel sequencer
    logic                        r_busy;
    logic [1:0]                  r_cnt;
    logic signed [31:0]          r_vx, r_vy, r_wz;
    logic [sik_pkg::STAMP_W-1:0] r_stamp;
    logic                        in_acc;

    assign o_in_ready = en && (!r_busy || r_cnt == 2'd2);
    assign in_acc     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (en) begin
            if (in_acc) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy && r_cnt == 2'd2) begin
                r_busy <= 1'b0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_vx    <= i_vel_x;
            r_vy    <= i_vel_y;
            r_wz    <= i_yaw_rate;
            r_stamp <= i_stamp_ns;
        end
    end

    // stage 1: yaw rate times wheel position
    logic signed [23:0] px_sel, py_sel;
    always_comb begin
        case (r_cnt)
            2'd0:    begin px_sel = r_pos_x[0]; py_sel = r_pos_y[0]; end
            2'd1:    begin px_sel = r_pos_x[1]; py_sel = r_pos_y[1]; end
            2'd2:    begin px_sel = r_pos_x[2]; py_sel = r_pos_y[2]; end
            default: begin px_sel = '0;         py_sel = '0;         end
        endcase
    end

    sik_pkg::t_tag      r1_tag;
    logic signed [55:0] r1_px, r1_py;
    logic signed [31:0] r1_vx, r1_vy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_tag <= '0;
        end else if (en) begin
            r1_tag.vld   <= r_busy;
            r1_tag.wheel <= r_cnt;
            r1_tag.last  <= (r_cnt == 2'd2);
            r1_tag.stamp <= r_stamp;
            r1_tag.nul   <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_px <= r_wz * px_sel;
            r1_py <= r_wz * py_sel;
            r1_vx <= r_vx;
            r1_vy <= r_vy;
        end
    end

    // stage 2: wheel ground velocity
    sik_pkg::t_tag                  r2_tag, n2_tag;
    logic signed [sik_pkg::VW-1:0]  r2_wx, r2_wy, n2_wx, n2_wy;

    always_comb begin
        n2_wx = sik_pkg::VW'(r1_vx)
              - sik_pkg::VW'(signed'(r1_py[55:sik_pkg::FRAC_BITS]));
        n2_wy = sik_pkg::VW'(r1_vy)
              + sik_pkg::VW'(signed'(r1_px[55:sik_pkg::FRAC_BITS]));
        n2_tag     = r1_tag;
        n2_tag.nul = (n2_wx == '0) && (n2_wy == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_tag <= '0;
        end else if (en) begin
            r2_tag <= n2_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_wx <= n2_wx;
            r2_wy <= n2_wy;
        end
    end

    // stage 3: fold the left half plane onto the right
    sik_pkg::t_tag                 c_tag [NC+1];
    logic signed [sik_pkg::XW-1:0] c_x   [NC+1];
    logic signed [sik_pkg::XW-1:0] c_y   [NC+1];
    logic signed [sik_pkg::ZW-1:0] c_z   [NC+1];
    logic signed [sik_pkg::XW-1:0] wx_e, wy_e;

    assign wx_e = sik_pkg::XW'(r2_wx);
    assign wy_e = sik_pkg::XW'(r2_wy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            c_tag[0] <= '0;
        end else if (en) begin
            c_tag[0] <= r2_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r2_wx < 0) begin
                c_x[0] <= -wx_e;
                c_y[0] <= -wy_e;
                c_z[0] <= (r2_wy >= 0) ? sik_pkg::PI_FRAC : -sik_pkg::PI_FRAC;
            end else begin
                c_x[0] <= wx_e;
                c_y[0] <= wy_e;
                c_z[0] <= '0;
            end
        end
    end

    for (genvar g = 0; g < NC; g++) begin : g_cordic
        sik_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_shift (5'(g)),
            .i_atan  (sik_pkg::atan_frac(g)),
            .i_tag   (c_tag[g]),
            .i_x     (c_x[g]),
            .i_y     (c_y[g]),
            .i_z     (c_z[g]),
            .o_tag   (c_tag[g+1]),
            .o_x     (c_x[g+1]),
            .o_y     (c_y[g+1]),
            .o_z     (c_z[g+1])
        );
    end

    // gain stage 1: clamp angle, split gain product
    sik_pkg::t_tag                  rg1_tag;
    logic signed [sik_pkg::ANG_W-1:0] rg1_ang;
    logic [sik_pkg::MW-1:0]         mag_in;
    logic [sik_pkg::MW-1:0]         rg1_hi;
    logic [59:0]                    rg1_lo;
    logic signed [sik_pkg::ZW-1:0]  zc;

    always_comb begin
        mag_in = (c_x[NC] > 0) ? c_x[NC][sik_pkg::MW-1:0] : '0;
        if (c_z[NC] > sik_pkg::PI_FRAC) begin
            zc = sik_pkg::PI_FRAC;
        end else if (c_z[NC] < -sik_pkg::PI_FRAC) begin
            zc = -sik_pkg::PI_FRAC;
        end else begin
            zc = c_z[NC];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rg1_tag <= '0;
        end else if (en) begin
            rg1_tag <= c_tag[NC];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            rg1_ang <= c_tag[NC].nul ? '0 : zc[sik_pkg::ANG_W-1:0];
            rg1_hi  <= mag_in[sik_pkg::MW-1:30] * sik_pkg::INV_GAIN_Q30;
            rg1_lo  <= mag_in[29:0] * sik_pkg::INV_GAIN_Q30;
        end
    end

    // gain stage 2: combine partial products
    sik_pkg::t_tag                    rg2_tag;
    logic signed [sik_pkg::ANG_W-1:0] rg2_ang;
    logic [sik_pkg::MW-1:0]           rg2_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rg2_tag <= '0;
        end else if (en) begin
            rg2_tag <= rg1_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            rg2_ang <= rg1_ang;
            rg2_mag <= rg1_hi + sik_pkg::MW'(rg1_lo[59:30]);
        end
    end

    // divider entry: overflow check and initial partial remainder
    sik_pkg::t_dside                  d_side [ND+1];
    logic [sik_pkg::REM_W-1:0]        d_rem  [ND+1];
    logic [sik_pkg::LOW_W-1:0]        d_low  [ND+1];
    logic [sik_pkg::RATE_W-1:0]       d_quo  [ND+1];
    logic [sik_pkg::MW-1:0]           sat_lim;
    sik_pkg::t_dside                  n_side0;

    assign sat_lim = {{(sik_pkg::MW - sik_pkg::RW - sik_pkg::LOW_W){1'b0}},
                      r_radius, {sik_pkg::LOW_W{1'b0}}};

    always_comb begin
        n_side0.tag     = rg2_tag;
        n_side0.tag.nul = rg2_tag.nul || (rg2_mag == '0);
        n_side0.sat     = (rg2_mag >= sat_lim);
        n_side0.angle   = rg2_ang;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            d_side[0] <= '0;
        end else if (en) begin
            d_side[0] <= n_side0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            d_rem[0] <= {1'b0, rg2_mag[sik_pkg::RW+sik_pkg::LOW_W-1:sik_pkg::LOW_W]};
            d_low[0] <= rg2_mag[sik_pkg::LOW_W-1:0];
            d_quo[0] <= '0;
        end
    end

    for (genvar g = 0; g < ND; g++) begin : g_div
        sik_div_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (en),
            .i_radius (r_radius),
            .i_side   (d_side[g]),
            .i_rem    (d_rem[g]),
            .i_low    (d_low[g]),
            .i_quo    (d_quo[g]),
            .o_side   (d_side[g+1]),
            .o_rem    (d_rem[g+1]),
            .o_low    (d_low[g+1]),
            .o_quo    (d_quo[g+1])
        );
    end

    // output register
    logic [1:0]                       r_o_wheel;
    logic signed [sik_pkg::ANG_W-1:0] r_o_angle;
    logic [sik_pkg::RATE_W-1:0]       r_o_rate;
    logic [sik_pkg::STAMP_W-1:0]      r_o_stamp;
    logic                             r_o_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= d_side[ND].tag.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_wheel <= d_side[ND].tag.wheel;
            r_o_last  <= d_side[ND].tag.last;
            r_o_stamp <= d_side[ND].tag.stamp;
            r_o_angle <= d_side[ND].angle;
            if (d_side[ND].tag.nul) begin
                r_o_rate <= '0;
            end else if (d_side[ND].sat) begin
                r_o_rate <= sik_pkg::RATE_MAX;
            end else begin
                r_o_rate <= d_quo[ND];
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_wheel_num    = r_o_wheel;
    assign o_steer_angle  = r_o_angle;
    assign o_wheel_rate   = r_o_rate;
    assign o_out_stamp_ns = r_o_stamp;
    assign o_last_wheel   = r_o_last;
endmodule

// ----- rtl/sik_checker.sv -----
// ---------------------------------------------------------------------------
// sik_checker: port-level checks on the swerve inverse kinematics outputs
// Watches the result channel only.
// ---------------------------------------------------------------------------
module sik_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_out_valid,
    input logic                               i_out_ready,
    input logic [1:0]                         o_wheel_num,
    input logic signed [sik_pkg::ANG_W-1:0]   o_steer_angle,
    input logic [sik_pkg::RATE_W-1:0]         o_wheel_rate,
    input logic                               o_last_wheel
);
    // a stalled transaction holds its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_wheel_num)
            && $stable(o_steer_angle) && $stable(o_wheel_rate))
        else $error("result changed while stalled");

    a_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_wheel_num != 2'd3)
        else $error("wheel number out of range");

    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_last_wheel == (o_wheel_num == 2'd2)))
        else $error("last flag not on third wheel");

    a_angle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_steer_angle <= sik_pkg::ANG_W'(205887))
            && (o_steer_angle >= -sik_pkg::ANG_W'(205887)))
        else $error("steer angle beyond pi");
endmodule

bind swerve_inverse_kinematics sik_checker u_sik_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_wheel_num   (o_wheel_num),
    .o_steer_angle (o_steer_angle),
    .o_wheel_rate  (o_wheel_rate),
    .o_last_wheel  (o_last_wheel)
);
